// ----- sv/vtaabb_pkg.sv -----
// Shared constants, types and helper functions for the vertex transform
// bounding box core. No dependencies.
`timescale 1ns / 1ps

package vtaabb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int IN_DATA_W  = 3 * COORD_W;
    localparam int OUT_DATA_W = 6 * COORD_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2 * COORD_W;
    localparam int NUM_ROWS   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MODE = 3'd6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    localparam coord_t ONE_Q     = coord_t'(64'd1 << FRAC_BITS);
    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    function automatic coord_t sat_coord(input sum_t v);
        coord_t r;
        if (v > sum_t'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (v < sum_t'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/vertex_transform_aabb_core.sv -----
// Top level of the vertex transform bounding box core: affine transform,
// saturation and running per-axis min/max. Depends on vtaabb_pkg.
`timescale 1ns / 1ps

// The core takes one vertex request per clock while s_tready is high and
// transforms it by the configured 3x4 matrix (or adds only the translation
// column), saturating each axis to Q16.16. Running minima and maxima
// restart on a vertex with tuser set and the box is emitted on the vertex
// with tlast set. A vertex passes an input register, a product register, a
// transform register and the bounds/output register; the rate is one vertex
// per cycle unless a vertex with tlast is held by a waiting box. While a
// box waits, vertices without tlast keep updating the bounds; the next
// vertex with tlast holds in the bounds stage, two more vertices fill the
// stages behind it and then s_tready falls.
module vertex_transform_aabb_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [vtaabb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vtaabb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: vert_x, vert_y, vert_z.
    input  logic [vtaabb_pkg::IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: first_vertex.
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: box_min_x, box_min_y, box_min_z,
    // box_max_x, box_max_y, box_max_z.
    output logic [vtaabb_pkg::OUT_DATA_W-1:0] m_tdata
);

    import vtaabb_pkg::*;

    logic [CFG_DATA_W-1:0] c01_reg [NUM_ROWS];
    logic [CFG_DATA_W-1:0] c23_reg [NUM_ROWS];
    logic                  full_reg;

    logic   s1_valid_reg, s1_first_reg, s1_last_reg;
    coord_t s1_coord_reg [NUM_ROWS];

    logic   s2_valid_reg, s2_first_reg, s2_last_reg;
    coord_t s2_coord_reg [NUM_ROWS];
    prod_t  s2_prod_reg  [NUM_ROWS][NUM_ROWS];
    prod_t  prod_next    [NUM_ROWS][NUM_ROWS];

    logic   s3_valid_reg, s3_first_reg, s3_last_reg;
    coord_t s3_xf_reg [NUM_ROWS];
    coord_t xf_next   [NUM_ROWS];

    coord_t run_min_reg [NUM_ROWS];
    coord_t run_max_reg [NUM_ROWS];
    coord_t min_next    [NUM_ROWS];
    coord_t max_next    [NUM_ROWS];

    logic   m_valid_reg;
    coord_t box_min_reg [NUM_ROWS];
    coord_t box_max_reg [NUM_ROWS];

    logic out_free, s3_go, s3_can, s2_can, s1_can;

    assign out_free = !m_valid_reg || m_tready;
    assign s3_go    = s3_valid_reg && (!s3_last_reg || out_free);
    assign s3_can   = !s3_valid_reg || s3_go;
    assign s2_can   = !s2_valid_reg || s3_can;
    assign s1_can   = !s1_valid_reg || s2_can;
    assign s_tready = s1_can;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c01_reg[0] <= {{COORD_W{1'b0}}, ONE_Q};
            c23_reg[0] <= '0;
            c01_reg[1] <= {ONE_Q, {COORD_W{1'b0}}};
            c23_reg[1] <= '0;
            c01_reg[2] <= '0;
            c23_reg[2] <= {{COORD_W{1'b0}}, ONE_Q};
            full_reg   <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROW0_C01:  c01_reg[0] <= cfg_data;
                REG_ROW0_C23:  c23_reg[0] <= cfg_data;
                REG_ROW1_C01:  c01_reg[1] <= cfg_data;
                REG_ROW1_C23:  c23_reg[1] <= cfg_data;
                REG_ROW2_C01:  c01_reg[2] <= cfg_data;
                REG_ROW2_C23:  c23_reg[2] <= cfg_data;
                REG_FULL_MODE: full_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage 1: input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_can) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_can && s_tvalid) begin
            s1_first_reg <= s_tuser;
            s1_last_reg  <= s_tlast;
            for (int i = 0; i < NUM_ROWS; i++) begin
                s1_coord_reg[i] <= s_tdata[i*COORD_W +: COORD_W];
            end
        end
    end

    // Stage 2: the nine coefficient products.
    always_comb begin
        coord_t coef;
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_ROWS; c++) begin
                if (c == 0) begin
                    coef = c01_reg[r][COORD_W-1:0];
                end else if (c == 1) begin
                    coef = c01_reg[r][CFG_DATA_W-1:COORD_W];
                end else begin
                    coef = c23_reg[r][COORD_W-1:0];
                end
                prod_next[r][c] = coef * s1_coord_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_can) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_can && s1_valid_reg) begin
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_coord_reg <= s1_coord_reg;
            s2_prod_reg  <= prod_next;
        end
    end

    // Stage 3: exact sum, floor shift (full mode), translation, saturation.
    always_comb begin
        sum_t sum, shifted, trans;
        for (int r = 0; r < NUM_ROWS; r++) begin
            trans   = sum_t'(coord_t'(c23_reg[r][CFG_DATA_W-1:COORD_W]));
            sum     = sum_t'(s2_prod_reg[r][0]) + sum_t'(s2_prod_reg[r][1])
                    + sum_t'(s2_prod_reg[r][2]);
            shifted = sum >>> FRAC_BITS;
            if (full_reg) begin
                xf_next[r] = sat_coord(shifted + trans);
            end else begin
                xf_next[r] = sat_coord(sum_t'(s2_coord_reg[r]) + trans);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_can) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_can && s2_valid_reg) begin
            s3_first_reg <= s2_first_reg;
            s3_last_reg  <= s2_last_reg;
            s3_xf_reg    <= xf_next;
        end
    end

    // Stage 4: running bounds and the box output register.
    always_comb begin
        coord_t base_min, base_max;
        for (int r = 0; r < NUM_ROWS; r++) begin
            base_min    = s3_first_reg ? COORD_MAX : run_min_reg[r];
            base_max    = s3_first_reg ? COORD_MIN : run_max_reg[r];
            min_next[r] = (s3_xf_reg[r] < base_min) ? s3_xf_reg[r] : base_min;
            max_next[r] = (s3_xf_reg[r] > base_max) ? s3_xf_reg[r] : base_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                run_min_reg[r] <= COORD_MAX;
                run_max_reg[r] <= COORD_MIN;
            end
        end else if (s3_go) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                run_min_reg[r] <= s3_last_reg ? COORD_MAX : min_next[r];
                run_max_reg[r] <= s3_last_reg ? COORD_MIN : max_next[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s3_go && s3_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_go && s3_last_reg) begin
            box_min_reg <= min_next;
            box_max_reg <= max_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            m_tdata[r*COORD_W +: COORD_W]              = box_min_reg[r];
            m_tdata[(r+NUM_ROWS)*COORD_W +: COORD_W]   = box_max_reg[r];
        end
    end

endmodule
